// ===== rtl/core/crr_pkg.sv =====
package crr_pkg;

  localparam int FieldW         = 21;
  localparam int StatusW        = 3;
  localparam int CfgIdxW        = 2;
  localparam int OffsetBitsDef  = 21;
  localparam int BounceBytesDef = 4096;

  localparam logic [FieldW-1:0] LowReset  = FieldW'(4096);
  localparam logic [FieldW-1:0] HighReset = FieldW'(1048576);
  localparam logic              CapReset  = 1'b0;

  localparam logic [CfgIdxW-1:0] CfgRingLow        = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgRingHigh       = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgReserveCapable = CfgIdxW'(2);

  localparam logic ModeReserve = 1'b0;
  localparam logic ModeCommit  = 1'b1;

  typedef enum logic [StatusW-1:0] {
    ST_IN_PLACE       = 3'd0,
    ST_BOUNCE         = 3'd1,
    ST_FULL           = 3'd2,
    ST_TOO_LARGE      = 3'd3,
    ST_MISALIGNED     = 3'd4,
    ST_DOUBLE_RESERVE = 3'd5,
    ST_NO_RESERVE     = 3'd6
  } status_e;

  typedef struct packed {
    logic              mode;
    logic [FieldW-1:0] byte_count;
    logic [FieldW-1:0] stop_offset;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [FieldW-1:0] place_offset;
    logic [FieldW-1:0] reserved_word;
    logic [FieldW-1:0] first_chunk_bytes;
    logic              bounce_used;
  } rsp_t;

  typedef struct packed {
    logic               we;
    logic [CfgIdxW-1:0] idx;
    logic [FieldW-1:0]  data;
  } cfg_wr_t;

endpackage

// ===== rtl/core/crr_if.sv =====
interface crr_req_if import crr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [FieldW-1:0] byte_count;
  logic [FieldW-1:0] stop_offset;

  modport source (output valid, mode, byte_count, stop_offset, input ready);
  modport sink (input valid, mode, byte_count, stop_offset, output ready);
endinterface

interface crr_rsp_if import crr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [StatusW-1:0] status;
  logic [FieldW-1:0] place_offset;
  logic [FieldW-1:0] reserved_word;
  logic [FieldW-1:0] first_chunk_bytes;
  logic              bounce_used;

  modport source (output valid, status, place_offset, reserved_word, first_chunk_bytes,
                  bounce_used, input ready);
  modport sink (input valid, status, place_offset, reserved_word, first_chunk_bytes,
                bounce_used, output ready);
endinterface

// ===== rtl/core/crr_in_stage.sv =====
module crr_in_stage import crr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  req_t req_i,
  input  logic adv_i,
  output logic ready_o,
  output logic valid_o,
  output req_t req_o
);

  logic valid_q;
  req_t req_q;
  logic load;

  assign ready_o = !valid_q || adv_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (adv_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q <= req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

// ===== rtl/core/crr_engine.sv =====
module crr_engine import crr_pkg::*; #(
  parameter int BOUNCE_BYTES = BounceBytesDef,
  parameter int OFFSET_BITS  = OffsetBitsDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_wr_t cfg_i,
  input  logic    fire_i,
  input  req_t    req_i,
  output rsp_t    rsp_o
);

  localparam int CalcW = ((OFFSET_BITS > FieldW) ? OFFSET_BITS : FieldW) + 3;
  localparam logic signed [CalcW-1:0] BounceS = CalcW'(BOUNCE_BYTES);

  logic [FieldW-1:0]      low_q, high_q;
  logic                   cap_q;
  logic [OFFSET_BITS-1:0] next_q, next_d;
  logic [FieldW-1:0]      open_q, open_d;
  logic                   bounce_q, bounce_d;

  logic signed [CalcW-1:0] b_s, st_s, mn_s, mx_s, nx_s, span_s, open_s;
  logic signed [CalcW-1:0] c_s, c_cut, sum_s, room_s, chunk_s;
  logic                    inplace, bounce;
  rsp_t                    rsp;

  always_comb begin
    b_s    = $signed({{(CalcW-FieldW){1'b0}}, req_i.byte_count});
    st_s   = $signed({{(CalcW-FieldW){1'b0}}, req_i.stop_offset});
    mn_s   = $signed({{(CalcW-FieldW){1'b0}}, low_q});
    mx_s   = $signed({{(CalcW-FieldW){1'b0}}, high_q});
    nx_s   = $signed({{(CalcW-OFFSET_BITS){1'b0}}, next_q});
    open_s = $signed({{(CalcW-FieldW){1'b0}}, open_q});
    span_s = (mx_s > mn_s) ? (mx_s - mn_s) : '0;

    c_s     = {b_s[CalcW-1:2], 2'b00};
    c_cut   = (c_s > open_s) ? open_s : c_s;
    sum_s   = nx_s + c_cut;
    room_s  = mx_s - nx_s;
    chunk_s = '0;
    inplace = 1'b0;
    bounce  = 1'b0;

    next_d   = next_q;
    open_d   = open_q;
    bounce_d = bounce_q;

    rsp.status            = ST_FULL;
    rsp.place_offset      = '0;
    rsp.reserved_word     = '0;
    rsp.first_chunk_bytes = '0;
    rsp.bounce_used       = 1'b0;

    if (req_i.mode == ModeReserve) begin
      if (b_s > BounceS || b_s > span_s) begin
        rsp.status = ST_TOO_LARGE;
      end else if (req_i.byte_count[1:0] != 2'b00) begin
        rsp.status = ST_MISALIGNED;
      end else if (open_q != '0) begin
        rsp.status = ST_DOUBLE_RESERVE;
      end else begin
        if (nx_s >= st_s) begin
          if ((nx_s + b_s < mx_s) || ((nx_s + b_s == mx_s) && (st_s > mn_s))) begin
            inplace = 1'b1;
          end else if (room_s + (st_s - mn_s) > b_s) begin
            bounce = 1'b1;
          end
        end else if (nx_s + b_s < st_s) begin
          inplace = 1'b1;
        end
        if (inplace && !(cap_q || b_s <= CalcW'(4))) begin
          inplace = 1'b0;
          bounce  = 1'b1;
        end
        if (inplace) begin
          open_d            = req_i.byte_count;
          bounce_d          = 1'b0;
          rsp.status        = ST_IN_PLACE;
          rsp.place_offset  = FieldW'(next_q);
          rsp.reserved_word = cap_q ? req_i.byte_count : '0;
        end else if (bounce) begin
          open_d          = req_i.byte_count;
          bounce_d        = 1'b1;
          rsp.status      = ST_BOUNCE;
          rsp.bounce_used = 1'b1;
        end else begin
          rsp.status = ST_FULL;
        end
      end
    end else begin
      if (open_q == '0) begin
        rsp.status = ST_NO_RESERVE;
      end else begin
        open_d = '0;
        if (bounce_q && cap_q && (nx_s < mx_s)) begin
          chunk_s = (c_cut < room_s) ? c_cut : room_s;
        end
        if ((span_s > 0) && (sum_s >= mx_s)) begin
          sum_s = sum_s - span_s;
        end
        next_d                = sum_s[OFFSET_BITS-1:0];
        rsp.status            = bounce_q ? ST_BOUNCE : ST_IN_PLACE;
        rsp.place_offset      = FieldW'(next_d);
        rsp.first_chunk_bytes = chunk_s[FieldW-1:0];
        rsp.bounce_used       = bounce_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q    <= LowReset;
      high_q   <= HighReset;
      cap_q    <= CapReset;
      next_q   <= OFFSET_BITS'(LowReset);
      open_q   <= '0;
      bounce_q <= 1'b0;
    end else if (cfg_i.we) begin
      if (cfg_i.idx == CfgRingLow) begin
        low_q  <= cfg_i.data;
        next_q <= OFFSET_BITS'(cfg_i.data);
      end else if (cfg_i.idx == CfgRingHigh) begin
        high_q <= cfg_i.data;
      end else if (cfg_i.idx == CfgReserveCapable) begin
        cap_q <= cfg_i.data[0];
      end
    end else if (fire_i) begin
      next_q   <= next_d;
      open_q   <= open_d;
      bounce_q <= bounce_d;
    end
  end

  assign rsp_o = rsp;

endmodule

// ===== rtl/core/crr_out_stage.sv =====
module crr_out_stage import crr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  rsp_t rsp_i,
  input  logic ready_i,
  output logic adv_o,
  output logic valid_o,
  output rsp_t rsp_o
);

  logic valid_q;
  rsp_t rsp_q;

  assign adv_o = valid_i && (!valid_q || ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      rsp_q <= rsp_i;
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

// ===== rtl/core/command_ring_reserve_commit_top.sv =====
// producer side of a circular command ring between ring_low_offset and ring_high_offset
// req_i carries one request: mode (reserve or commit), byte_count and the consumer's
// stop_offset; rsp_o returns exactly one response per request, in order
// responses: status, place_offset, reserved_word, first_chunk_bytes, bounce_used
// a full status changes nothing, so the caller retries the same reserve later
// both channels are valid/ready; a request is taken when valid and ready are high
// a request is captured in the input register, then passes through the decision logic
// into the result register, which drives rsp_o
// throughput: one request per cycle while rsp_o is not stalled; the ring pointer, open
// reservation size and bounce flag update in the cycle a request moves into the result register
// when rsp_o is stalled the result register holds and the input register fills, then
// req_i.ready drops; no request is lost or repeated
// reset clears the valid flags of both registers and loads next offset with the ring low
// reset value; cfg_we_i writes register cfg_idx_i (0 low, 1 high, 2 reserve capable) and a
// low write also reloads next offset; the user must write only while idle (not enforced)
module command_ring_reserve_commit_top import crr_pkg::*; #(
  parameter int BOUNCE_BYTES = BounceBytesDef,
  parameter int OFFSET_BITS  = OffsetBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [FieldW-1:0]  cfg_wdata_i,
  crr_req_if.sink            req_i,
  crr_rsp_if.source          rsp_o
);

  req_t    req_in, req_q;
  rsp_t    rsp_d, rsp_q;
  cfg_wr_t cfg;
  logic    in_valid, adv, in_ready, out_valid;

  assign req_in.mode        = req_i.mode;
  assign req_in.byte_count  = req_i.byte_count;
  assign req_in.stop_offset = req_i.stop_offset;
  assign req_i.ready        = in_ready;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_wdata_i;

  crr_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_i.valid),
    .req_i   (req_in),
    .adv_i   (adv),
    .ready_o (in_ready),
    .valid_o (in_valid),
    .req_o   (req_q)
  );

  crr_engine #(
    .BOUNCE_BYTES (BOUNCE_BYTES),
    .OFFSET_BITS  (OFFSET_BITS)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .fire_i (adv),
    .req_i  (req_q),
    .rsp_o  (rsp_d)
  );

  crr_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid),
    .rsp_i   (rsp_d),
    .ready_i (rsp_o.ready),
    .adv_o   (adv),
    .valid_o (out_valid),
    .rsp_o   (rsp_q)
  );

  assign rsp_o.valid             = out_valid;
  assign rsp_o.status            = rsp_q.status;
  assign rsp_o.place_offset      = rsp_q.place_offset;
  assign rsp_o.reserved_word     = rsp_q.reserved_word;
  assign rsp_o.first_chunk_bytes = rsp_q.first_chunk_bytes;
  assign rsp_o.bounce_used       = rsp_q.bounce_used;

endmodule
